// File: design/landmark_lower_bound_query_top_assert.svh
// ----------------------------------------------------------------------------
// landmark lower bound query - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef LANDMARK_LOWER_BOUND_QUERY_TOP_ASSERT_SVH
`define LANDMARK_LOWER_BOUND_QUERY_TOP_ASSERT_SVH

// same-cycle implication
`define LLBQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LLBQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/llbq_pkg.sv
// ----------------------------------------------------------------------------
// llbq_pkg
// Types, codes and default sizes for the landmark lower bound query block.
// ----------------------------------------------------------------------------
`default_nettype none

package llbq_pkg;

  localparam int unsigned DEF_MAX_NODES = 1024;
  localparam int unsigned DEF_LM_SLOTS  = 8;
  localparam int unsigned DEF_MAX_PAIRS = 256;

  localparam int unsigned DATA_W = 32;

  typedef logic [1:0]        req_type_t;
  typedef logic signed [15:0] node_id_t;
  typedef logic [9:0]        entry_index_t;
  typedef logic [2:0]        lm_slot_t;
  typedef logic [DATA_W-1:0] dist_t;
  typedef logic [1:0]        src_t;
  typedef logic [1:0]        cfg_index_t;
  typedef logic [10:0]       cfg_data_t;

  localparam req_type_t REQ_QUERY = 2'd0;
  localparam req_type_t REQ_DIST  = 2'd1;
  localparam req_type_t REQ_PAIR  = 2'd2;

  localparam src_t SRC_FALLBACK = 2'd0;
  localparam src_t SRC_LANDMARK = 2'd1;

  localparam cfg_index_t CFG_NODE_COUNT = 2'd0;
  localparam cfg_index_t CFG_LM_COUNT   = 2'd1;
  localparam cfg_index_t CFG_PAIR_COUNT = 2'd2;

  typedef struct packed {
    logic abs_mode;
    logic skip;
  } unit_op_t;

  typedef struct packed {
    logic  gt;
    dist_t value;
  } unit_res_t;

endpackage

`default_nettype wire

// File: design/llbq_if.sv
// ----------------------------------------------------------------------------
// llbq_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface llbq_req_if;
  logic                    valid;
  logic                    ready;
  llbq_pkg::req_type_t     req_type;
  llbq_pkg::node_id_t      from_node;
  llbq_pkg::node_id_t      to_node;
  llbq_pkg::entry_index_t  entry_index;
  llbq_pkg::lm_slot_t      landmark_slot;
  llbq_pkg::dist_t         distance_value;
  logic                    distance_infinite;
  llbq_pkg::src_t          pair_source;

  modport source (
    output valid, req_type, from_node, to_node, entry_index, landmark_slot,
           distance_value, distance_infinite, pair_source,
    input  ready
  );
  modport sink (
    input  valid, req_type, from_node, to_node, entry_index, landmark_slot,
           distance_value, distance_infinite, pair_source,
    output ready
  );
endinterface

interface llbq_res_if;
  logic            valid;
  logic            ready;
  logic            valid_res;
  llbq_pkg::dist_t bound;
  llbq_pkg::src_t  bound_src;

  modport source (
    output valid, valid_res, bound, bound_src,
    input  ready
  );
  modport sink (
    input  valid, valid_res, bound, bound_src,
    output ready
  );
endinterface

`default_nettype wire

// File: design/llbq_ram.sv
// ----------------------------------------------------------------------------
// llbq_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module llbq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/llbq_unit.sv
// ----------------------------------------------------------------------------
// llbq_unit
// Shared difference and compare unit: |a-b| or a, tested against the best.
// ----------------------------------------------------------------------------
`default_nettype none

module llbq_unit (
  input  wire llbq_pkg::unit_op_t op,
  input  wire llbq_pkg::dist_t    op_a,
  input  wire llbq_pkg::dist_t    op_b,
  input  wire llbq_pkg::dist_t    best,
  output llbq_pkg::unit_res_t     res
);
  import llbq_pkg::*;

  dist_t mag;
  dist_t value;

  always_comb begin
    mag       = (op_a >= op_b) ? (op_a - op_b) : (op_b - op_a);
    value     = op.abs_mode ? mag : op_a;
    res.value = value;
    res.gt    = !op.skip && (value > best);
  end

endmodule

`default_nettype wire

// File: design/landmark_lower_bound_query_top.sv
// ----------------------------------------------------------------------------
// landmark_lower_bound_query_top
// Landmark triangle lower bound with stored pair bound override.
// ----------------------------------------------------------------------------
// One request word at a time. A query that passes the id checks reads
// L = min(lm_count, LM_SLOTS) landmarks and then scans the pair slots up to
// and including the first key match (at most min(pair_count, MAX_PAIRS)):
// the distance memory has one read port, so each landmark costs two reads,
// and the pair memory is scanned one slot a cycle. Write words and queries
// settled by the id checks go straight to the output stage. The result sits
// in an output register, so the next word is taken while the last result
// waits.
`default_nettype none

`include "landmark_lower_bound_query_top_assert.svh"

module landmark_lower_bound_query_top #(
  parameter int unsigned MAX_NODES = llbq_pkg::DEF_MAX_NODES,
  parameter int unsigned LM_SLOTS  = llbq_pkg::DEF_LM_SLOTS,
  parameter int unsigned MAX_PAIRS = llbq_pkg::DEF_MAX_PAIRS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  llbq_req_if.sink                  req,
  llbq_res_if.source                res,
  input  wire logic                 cfg_we,
  input  wire llbq_pkg::cfg_index_t cfg_index,
  input  wire llbq_pkg::cfg_data_t  cfg_data
);
  import llbq_pkg::*;

  localparam int unsigned DistDepth = MAX_NODES * LM_SLOTS;
  localparam int unsigned DistAw    = (DistDepth > 1) ? $clog2(DistDepth) : 1;
  localparam int unsigned PairAw    = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int unsigned PairCw    = $clog2(MAX_PAIRS + 1);
  localparam int unsigned LmCw      = $clog2(LM_SLOTS + 1);
  localparam int unsigned PairW     = 2 * DATA_W + 2;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LMA  = 3'd1;
  localparam logic [2:0] ST_LMB  = 3'd2;
  localparam logic [2:0] ST_PAIR = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [10:0] node_count;
  logic [3:0]  lm_count;
  logic [8:0]  pair_count;

  logic [2:0]        state;
  logic              out_valid;
  logic              out_valid_res;
  dist_t             out_bound;
  src_t              out_source;

  logic              r_ok;
  dist_t             best;
  src_t              src;
  logic [DATA_W-1:0] q_key;
  logic [DistAw-1:0] addr_a;
  logic [DistAw-1:0] addr_b;
  logic [LmCw-1:0]   lm_idx;
  logic [PairCw-1:0] pk;
  logic              pv;
  logic              eval_pend;
  logic [DATA_W:0]   ea_reg;

  logic              acc;
  logic              is_query;
  logic              ids_eq;
  logic              a_ok;
  logic              b_ok;
  logic              range_ok;
  logic [DATA_W-1:0] base_a;
  logic [DATA_W-1:0] base_b;
  logic              lm_more;
  logic              pk_more;
  logic              key_match;
  logic              out_load;

  logic              dist_we;
  logic [DistAw-1:0] dist_waddr;
  logic [DATA_W:0]   dist_wdata;
  logic [DistAw-1:0] dist_raddr;
  logic [DATA_W:0]   dist_rdata;
  logic              pair_we;
  logic [PairW-1:0]  pair_wdata;
  logic [PairW-1:0]  pair_rdata;

  unit_op_t          u_op;
  dist_t             u_a;
  dist_t             u_b;
  unit_res_t         u_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
      lm_count   <= '0;
      pair_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_COUNT: node_count <= cfg_data;
        CFG_LM_COUNT:   lm_count   <= cfg_data[3:0];
        CFG_PAIR_COUNT: pair_count <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // request decode
  always_comb begin
    acc      = req.valid && req.ready;
    is_query = (req.req_type == REQ_QUERY);
    ids_eq   = (req.from_node == req.to_node) && !req.from_node[15];
    a_ok     = !req.from_node[15] && (req.from_node != '0)
               && (32'(req.from_node[14:0]) <= 32'(node_count))
               && (32'(req.from_node[14:0]) <= 32'(MAX_NODES));
    b_ok     = !req.to_node[15] && (req.to_node != '0)
               && (32'(req.to_node[14:0]) <= 32'(node_count))
               && (32'(req.to_node[14:0]) <= 32'(MAX_NODES));
    range_ok = (node_count != '0) && (lm_count != '0) && a_ok && b_ok;
    base_a   = (32'(req.from_node[14:0]) - 32'd1) * 32'(LM_SLOTS);
    base_b   = (32'(req.to_node[14:0]) - 32'd1) * 32'(LM_SLOTS);
    lm_more  = (32'(lm_idx) < 32'(lm_count))
               && (32'(lm_idx) < 32'(LM_SLOTS));
    pk_more  = (32'(pk) < 32'(pair_count)) && (32'(pk) < 32'(MAX_PAIRS));
    key_match = (pair_rdata[PairW-1 -: DATA_W] == q_key);
    out_load = (state == ST_DONE) && (!out_valid || res.ready);
  end

  // memory ports
  always_comb begin
    dist_we    = acc && (req.req_type == REQ_DIST)
                 && (32'(req.entry_index) < 32'(MAX_NODES))
                 && (32'(req.landmark_slot) < 32'(LM_SLOTS));
    dist_waddr = DistAw'(32'(req.entry_index) * 32'(LM_SLOTS)
                 + 32'(req.landmark_slot));
    dist_wdata = req.distance_infinite ? {1'b1, {DATA_W{1'b0}}}
                                       : {1'b0, req.distance_value};
    dist_raddr = (state == ST_LMB) ? addr_b : addr_a;
    pair_we    = acc && (req.req_type == REQ_PAIR)
                 && (32'(req.entry_index) < 32'(MAX_PAIRS));
    pair_wdata = {req.from_node, req.to_node, req.pair_source, req.distance_value};
  end

  llbq_ram #(
    .WIDTH (DATA_W + 1),
    .DEPTH (DistDepth)
  ) u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (dist_raddr),
    .rdata (dist_rdata)
  );

  llbq_ram #(
    .WIDTH (PairW),
    .DEPTH (MAX_PAIRS)
  ) u_pair_ram (
    .clk   (clk),
    .we    (pair_we),
    .waddr (PairAw'(req.entry_index)),
    .wdata (pair_wdata),
    .raddr (pk[PairAw-1:0]),
    .rdata (pair_rdata)
  );

  // shared unit operand select
  always_comb begin
    if (state == ST_PAIR) begin
      u_op.abs_mode = 1'b0;
      u_op.skip     = 1'b0;
      u_a           = pair_rdata[DATA_W-1:0];
      u_b           = '0;
    end else begin
      u_op.abs_mode = 1'b1;
      u_op.skip     = ea_reg[DATA_W] || dist_rdata[DATA_W];
      u_a           = ea_reg[DATA_W-1:0];
      u_b           = dist_rdata[DATA_W-1:0];
    end
  end

  llbq_unit u_unit (
    .op   (u_op),
    .op_a (u_a),
    .op_b (u_b),
    .best (best),
    .res  (u_res)
  );

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (acc) begin
            if (is_query && !ids_eq && range_ok) begin
              state <= ST_LMA;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_LMA: begin
          state <= lm_more ? ST_LMB : ST_PAIR;
        end
        ST_LMB: begin
          state <= ST_LMA;
        end
        ST_PAIR: begin
          if ((pv && key_match) || !pk_more) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (acc) begin
          q_key     <= (req.from_node < req.to_node) ? {req.from_node, req.to_node}
                                                     : {req.to_node, req.from_node};
          addr_a    <= DistAw'(base_a);
          addr_b    <= DistAw'(base_b);
          lm_idx    <= '0;
          pk        <= '0;
          pv        <= 1'b0;
          eval_pend <= 1'b0;
          best      <= '0;
          if (is_query && ids_eq) begin
            r_ok <= 1'b1;
            src  <= SRC_FALLBACK;
          end else if (is_query && range_ok) begin
            r_ok <= 1'b1;
            src  <= SRC_LANDMARK;
          end else begin
            r_ok <= 1'b0;
            src  <= SRC_FALLBACK;
          end
        end
      end
      ST_LMA: begin
        if (eval_pend && u_res.gt) begin
          best <= u_res.value;
        end
        eval_pend <= 1'b0;
      end
      ST_LMB: begin
        ea_reg    <= dist_rdata;
        eval_pend <= 1'b1;
        addr_a    <= addr_a + DistAw'(1);
        addr_b    <= addr_b + DistAw'(1);
        lm_idx    <= lm_idx + LmCw'(1);
      end
      ST_PAIR: begin
        if (pv && key_match) begin
          if (u_res.gt) begin
            best <= u_res.value;
            src  <= pair_rdata[PairW-DATA_W-1 -: 2];
          end
        end else if (pk_more) begin
          pk <= pk + PairCw'(1);
          pv <= 1'b1;
        end else begin
          pv <= 1'b0;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_res <= r_ok;
          out_bound     <= best;
          out_source    <= src;
        end
      end
      default: ;
    endcase
  end

  assign req.ready     = (state == ST_IDLE);
  assign res.valid     = out_valid;
  assign res.valid_res = out_valid_res;
  assign res.bound     = out_bound;
  assign res.bound_src = out_source;

  `LLBQ_ASSERT_IMPL(a_invalid_zero, res.valid && !res.valid_res, (res.bound == '0) && (res.bound_src == SRC_FALLBACK), "invalid result word carries nonzero fields")
  `LLBQ_ASSERT_IMPL(a_lm_in_range, state == ST_LMB, lm_more, "landmark read past the landmarks in use")
  `LLBQ_ASSERT_NEXT(a_accept_busy, req.valid && req.ready, state != ST_IDLE, "accepted word did not start work")
  `LLBQ_ASSERT_NEXT(a_done_loads, out_load, res.valid && (state == ST_IDLE), "finished word not moved to output")

endmodule

`default_nettype wire

// File: verif/landmark_lower_bound_query_top_tb.sv
// ----------------------------------------------------------------------------
// landmark_lower_bound_query_top_tb
// Self-checking bench for the landmark lower bound query block. A directed
// table walks the id checks, the extreme distances and the pair override.
// Randomized phases then reprogram the node, landmark and pair counts, load
// the tables and fire queries with random gaps and result back-pressure.
// Each result word is matched against a pinned value or an in-bench bound calculator.
// ----------------------------------------------------------------------------
module landmark_lower_bound_query_top_tb;
  import llbq_pkg::*;

  localparam req_type_t REQ_UNUSED  = 2'd3;
  localparam src_t      SRC_PORTAL  = 2'd2;
  localparam src_t      SRC_CLUSTER = 2'd3;
  localparam int        NODE_LIM    = DEF_MAX_NODES;
  localparam int        LM_LIM      = DEF_LM_SLOTS;
  localparam int        PAIR_LIM    = DEF_MAX_PAIRS;

  typedef struct packed {
    req_type_t    kind;
    node_id_t     from_id;
    node_id_t     to_id;
    entry_index_t idx;
    lm_slot_t     lane;
    dist_t        value;
    logic         inf;
    src_t         psrc;
  } req_word_t;

  typedef struct packed {
    logic  valid_res;
    dist_t bound;
    src_t  source;
  } bound_res_t;

  typedef struct packed {
    logic       is_cfg;
    cfg_index_t reg_idx;
    cfg_data_t  reg_val;
    req_word_t  w;
    logic       pinned;
    bound_res_t want;
  } dir_row_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  cfg_index_t cfg_index;
  cfg_data_t  cfg_data;

  llbq_req_if req_ch ();
  llbq_res_if res_ch ();

  landmark_lower_bound_query_top uut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch.sink),
    .res       (res_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow tables and registers
  bit [32:0]  dist_mem  [NODE_LIM*LM_LIM];
  bit         dist_seen [NODE_LIM*LM_LIM];
  bit [31:0]  pair_key  [PAIR_LIM];
  bit [33:0]  pair_val  [PAIR_LIM];
  bit         pair_seen [PAIR_LIM];
  int         cfg_nodes;
  int         cfg_lms;
  int         cfg_pairs;

  bound_res_t pending_bounds [$];
  int         pool_ids [6];
  int         send_calm;
  int         take_calm;
  int         mismatch_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #24_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(8, 30);
    return $urandom_range(0, 15);
  endfunction

  function automatic void answer_query(input int a, input int b, output bound_res_t r,
                                       output bit blank);
    int        n, l, p, ia, ib;
    bit [15:0] ka, kb;
    bit [32:0] ea, eb;
    dist_t     d, best;
    src_t      src;
    r = '0;
    blank = 1'b0;
    n = (cfg_nodes > NODE_LIM) ? NODE_LIM : cfg_nodes;
    l = (cfg_lms > LM_LIM) ? LM_LIM : cfg_lms;
    p = (cfg_pairs > PAIR_LIM) ? PAIR_LIM : cfg_pairs;
    if (a == b && a >= 0) begin
      r.valid_res = 1'b1;
      r.source = SRC_FALLBACK;
      return;
    end
    if (n == 0 || l == 0) return;
    if (a < 1 || b < 1 || a > n || b > n) return;
    ia = a - 1;
    ib = b - 1;
    best = '0;
    src = SRC_LANDMARK;
    for (int lane = 0; lane < l; lane++) begin
      if (!dist_seen[ia*LM_LIM + lane] || !dist_seen[ib*LM_LIM + lane]) blank = 1'b1;
      ea = dist_mem[ia*LM_LIM + lane];
      eb = dist_mem[ib*LM_LIM + lane];
      if (ea[32] || eb[32]) continue;
      d = (ea[31:0] > eb[31:0]) ? ea[31:0] - eb[31:0] : eb[31:0] - ea[31:0];
      if (d > best) best = d;
    end
    ka = (a < b) ? a[15:0] : b[15:0];
    kb = (a < b) ? b[15:0] : a[15:0];
    for (int k = 0; k < p; k++) begin
      if (!pair_seen[k]) begin
        blank = 1'b1;
        break;
      end
      if (pair_key[k] != {ka, kb}) continue;
      if (pair_val[k][31:0] > best) begin
        best = pair_val[k][31:0];
        src = pair_val[k][33:32];
      end
      break;
    end
    r.valid_res = 1'b1;
    r.bound = best;
    r.source = src;
  endfunction

  function automatic bound_res_t apply_word(req_word_t w);
    bound_res_t r;
    bit         blank;
    int         slot;
    r = '0;
    slot = int'(w.idx) * LM_LIM + int'(w.lane);
    case (w.kind)
      REQ_QUERY: answer_query(int'($signed(w.from_id)), int'($signed(w.to_id)), r, blank);
      REQ_DIST: begin
        if (int'(w.idx) < NODE_LIM && int'(w.lane) < LM_LIM) begin
          dist_mem[slot] = w.inf ? {1'b1, 32'h0} : {1'b0, w.value};
          dist_seen[slot] = 1'b1;
        end
      end
      REQ_PAIR: begin
        if (int'(w.idx) < PAIR_LIM) begin
          pair_key[w.idx] = {w.from_id, w.to_id};
          pair_val[w.idx] = {w.psrc, w.value};
          pair_seen[w.idx] = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic req_word_t query_word(int a, int b);
    req_word_t w;
    w = '0;
    w.kind = REQ_QUERY;
    w.from_id = a[15:0];
    w.to_id = b[15:0];
    return w;
  endfunction

  function automatic req_word_t dist_word(int node, int lane, dist_t v, bit inf);
    req_word_t w;
    w = '0;
    w.kind = REQ_DIST;
    w.idx = node[9:0];
    w.lane = lane[2:0];
    w.value = v;
    w.inf = inf;
    return w;
  endfunction

  function automatic req_word_t pair_word(int slot, int a, int b, dist_t v, src_t s);
    req_word_t w;
    w = query_word(a, b);
    w.kind = REQ_PAIR;
    w.idx = slot[9:0];
    w.value = v;
    w.psrc = s;
    return w;
  endfunction

  function automatic dir_row_t row(req_word_t w);
    dir_row_t d;
    d = '0;
    d.w = w;
    return d;
  endfunction

  function automatic dir_row_t pinned(req_word_t w, logic vr, dist_t lb, src_t s);
    dir_row_t d;
    d = row(w);
    d.pinned = 1'b1;
    d.want = '{vr, lb, s};
    return d;
  endfunction

  function automatic dir_row_t reg_row(cfg_index_t i, cfg_data_t v);
    dir_row_t d;
    d = '0;
    d.is_cfg = 1'b1;
    d.reg_idx = i;
    d.reg_val = v;
    return d;
  endfunction

  function automatic dist_t pick_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return $urandom_range(0, 'hFFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic void pool_pair(output int lo, output int hi);
    int a, b;
    a = pool_ids[$urandom_range(0, 5)];
    b = pool_ids[$urandom_range(0, 5)];
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
  endfunction

  task automatic send_word(req_word_t w, bit use_want, bound_res_t want);
    bound_res_t got;
    int         gap;
    gap = draw_wait(send_calm);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.req_type          <= w.kind;
    req_ch.from_node         <= w.from_id;
    req_ch.to_node           <= w.to_id;
    req_ch.entry_index       <= w.idx;
    req_ch.landmark_slot     <= w.lane;
    req_ch.distance_value    <= w.value;
    req_ch.distance_infinite <= w.inf;
    req_ch.pair_source       <= w.psrc;
    req_ch.valid             <= 1'b1;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    got = apply_word(w);
    pending_bounds = {pending_bounds, (use_want ? want : got)};
  endtask

  task automatic drain_results();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_bounds.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, cfg_data_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_NODE_COUNT: cfg_nodes = int'(val);
      CFG_LM_COUNT:   cfg_lms = int'(val[3:0]);
      CFG_PAIR_COUNT: cfg_pairs = int'(val[8:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic setup_phase(int n, int l, int p);
    int lanes, lo, hi;
    drain_results();
    write_reg(CFG_NODE_COUNT, n[10:0]);
    write_reg(CFG_LM_COUNT, l[10:0]);
    write_reg(CFG_PAIR_COUNT, p[10:0]);
    foreach (pool_ids[i]) pool_ids[i] = (n < 1) ? $urandom_range(1, 2) : $urandom_range(1, n);
    pool_ids[0] = 1;
    pool_ids[1] = (n < 1) ? 2 : n;
    lanes = (l > LM_LIM) ? LM_LIM : l;
    if (n >= 1) begin
      foreach (pool_ids[i]) begin
        for (int lane = 0; lane < lanes; lane++) begin
          if (!dist_seen[(pool_ids[i] - 1)*LM_LIM + lane])
            send_word(dist_word(pool_ids[i] - 1, lane, pick_value(), $urandom_range(0, 4) == 0),
                      1'b0, '0);
        end
      end
    end
    for (int slot = 0; slot < p && slot < PAIR_LIM; slot++) begin
      if (!pair_seen[slot]) begin
        pool_pair(lo, hi);
        send_word(pair_word(slot, lo, hi, pick_value(), $urandom_range(0, 3)), 1'b0, '0);
      end
    end
  endtask

  task automatic draw_word(output req_word_t w);
    int         r, a, b, lo, hi, slot;
    bound_res_t probe;
    bit         blank;
    r = $urandom_range(0, 99);
    if (r < 62) begin
      w = query_word(pool_ids[$urandom_range(0, 5)], pool_ids[$urandom_range(0, 5)]);
    end else if (r < 70) begin
      a = pool_ids[$urandom_range(0, 5)];
      case ($urandom_range(0, 3))
        0: b = 0;
        1: b = cfg_nodes + 1;
        2: b = -1;
        default: b = $urandom_range(0, 65535);
      endcase
      w = $urandom_range(0, 1) ? query_word(a, b) : query_word(b, a);
    end else if (r < 76) begin
      w = query_word($urandom_range(0, 65535), $urandom_range(0, 65535));
    end else if (r < 79) begin
      a = $urandom_range(0, 65535);
      w = query_word(a, a);
    end else if (r < 91) begin
      a = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1023) : pool_ids[$urandom_range(0, 5)] - 1;
      w = dist_word(a, $urandom_range(0, 7), pick_value(), $urandom_range(0, 4) == 0);
    end else if (r < 98) begin
      pool_pair(lo, hi);
      slot = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
           : $urandom_range(0, (cfg_pairs > 0) ? cfg_pairs - 1 : 0);
      case ($urandom_range(0, 6))
        0: w = pair_word(slot, hi, lo, pick_value(), $urandom_range(0, 3));
        1: w = pair_word(slot, $urandom_range(0, 65535), $urandom_range(0, 65535),
                         pick_value(), $urandom_range(0, 3));
        default: w = pair_word(slot, lo, hi, pick_value(), $urandom_range(0, 3));
      endcase
    end else begin
      w = pair_word($urandom_range(0, 1023), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom, $urandom_range(0, 3));
      w.kind = REQ_UNUSED;
      w.lane = $urandom_range(0, 7);
      w.inf = $urandom_range(0, 1);
    end
    if (w.kind == REQ_QUERY) begin
      answer_query(int'($signed(w.from_id)), int'($signed(w.to_id)), probe, blank);
      if (blank) begin
        a = $urandom_range(0, 32767);
        w = query_word(a, a);
      end
    end
  endtask

  // result side
  initial begin
    bound_res_t exp_res;
    int         stall;
    res_ch.ready = 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = draw_wait(take_calm);
      @(negedge clk);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (res_ch.valid !== 1'b1) @(posedge clk);
      if (pending_bounds.size() == 0) begin
        $display("%0t: unexpected result word valid_res=%b bound=%h source=%0d",
                 $time, res_ch.valid_res, res_ch.bound, res_ch.bound_src);
        mismatch_count++;
      end else begin
        exp_res = pending_bounds.pop_front();
        if (res_ch.valid_res !== exp_res.valid_res) begin
          $display("%0t: valid_res expected %b got %b", $time, exp_res.valid_res,
                   res_ch.valid_res);
          mismatch_count++;
        end
        if (res_ch.bound !== exp_res.bound) begin
          $display("%0t: bound expected %h got %h", $time, exp_res.bound,
                   res_ch.bound);
          mismatch_count++;
        end
        if (res_ch.bound_src !== exp_res.source) begin
          $display("%0t: source expected %0d got %0d", $time, exp_res.source,
                   res_ch.bound_src);
          mismatch_count++;
        end
      end
    end
  end

  // request side
  initial begin
    dir_row_t  steps [$];
    req_word_t w;
    req_word_t junk;
    int        n, l, p;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_NODE_COUNT;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_QUERY;
    req_ch.from_node = '0;
    req_ch.to_node = '0;
    req_ch.entry_index = '0;
    req_ch.landmark_slot = '0;
    req_ch.distance_value = '0;
    req_ch.distance_infinite = 1'b0;
    req_ch.pair_source = '0;
    cfg_nodes = 0;
    cfg_lms = 0;
    cfg_pairs = 0;
    send_calm = 0;
    take_calm = 0;
    mismatch_count = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    junk = pair_word(1023, 32767, -32768, '1, SRC_CLUSTER);
    junk.kind = REQ_UNUSED;
    junk.lane = 3'd7;
    junk.inf = 1'b1;

    // empty tables right after reset
    steps = {steps, pinned(query_word(3, 5), 1'b0, '0, SRC_FALLBACK)};
    steps = {steps, pinned(query_word(7, 7), 1'b1, '0, SRC_FALLBACK)};
    steps = {steps, pinned(query_word(0, 0), 1'b1, '0, SRC_FALLBACK)};
    steps = {steps, pinned(query_word(-1, -1), 1'b0, '0, SRC_FALLBACK)};
    steps = {steps, pinned(query_word(-32768, 32767), 1'b0, '0, SRC_FALLBACK)};
    steps = {steps, pinned(junk, 1'b0, '0, SRC_FALLBACK)};
    steps = {steps, reg_row(CFG_NODE_COUNT, 11'd1024)};
    steps = {steps, reg_row(CFG_LM_COUNT, 11'd2)};
    steps = {steps, reg_row(CFG_PAIR_COUNT, 11'd2)};
    // first and last node, widest spread on lane 0, lane 1 unreachable
    steps = {steps, pinned(dist_word(0, 0, '1, 1'b0), 1'b0, '0, SRC_FALLBACK)};
    steps = {steps, pinned(dist_word(0, 1, 32'd0, 1'b1), 1'b0, '0, SRC_FALLBACK)};
    steps = {steps, pinned(dist_word(1023, 0, '0, 1'b0), 1'b0, '0, SRC_FALLBACK)};
    steps = {steps, pinned(dist_word(1023, 1, 32'd5, 1'b0), 1'b0, '0, SRC_FALLBACK)};
    // reversed keys never match; slot 300 is past the pair table
    steps = {steps, pinned(pair_word(0, 1024, 1, '1, SRC_CLUSTER), 1'b0, '0, SRC_FALLBACK)};
    steps = {steps, pinned(pair_word(1, 1, 1024, 32'd100, SRC_PORTAL), 1'b0, '0,
                           SRC_FALLBACK)};
    steps = {steps, pinned(pair_word(300, 1, 1024, '1, SRC_CLUSTER), 1'b0, '0,
                           SRC_FALLBACK)};
    steps = {steps, pinned(query_word(1, 1024), 1'b1, '1, SRC_LANDMARK)};
    steps = {steps, pinned(query_word(1024, 1), 1'b1, '1, SRC_LANDMARK)};
    steps = {steps, pinned(query_word(1, 1025), 1'b0, '0, SRC_FALLBACK)};
    steps = {steps, pinned(query_word(0, 1024), 1'b0, '0, SRC_FALLBACK)};
    steps = {steps, pinned(query_word(-32768, 1), 1'b0, '0, SRC_FALLBACK)};
    // no finite landmark left, then a pair bound that only ties
    steps = {steps, row(dist_word(0, 0, '0, 1'b1))};
    steps = {steps, row(query_word(1, 1024))};
    steps = {steps, row(pair_word(1, 1, 1024, '0, SRC_CLUSTER))};
    steps = {steps, row(query_word(1024, 1))};

    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        drain_results();
        write_reg(steps[i].reg_idx, steps[i].reg_val);
      end else begin
        send_word(steps[i].w, steps[i].pinned, steps[i].want);
      end
    end

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin n = 1024; l = 8; p = 96; end
        1: begin n = 1;    l = 1; p = 0;  end
        2: begin n = 0;    l = 8; p = 96; end
        3: begin n = 37;   l = 0; p = 17; end
        4: begin n = 2;    l = 8; p = 1;  end
        default: begin
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 1024) : $urandom_range(2, 40);
          l = $urandom_range(1, 8);
          p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 96) : $urandom_range(0, 16);
        end
      endcase
      setup_phase(n, l, p);
      repeat (22) begin
        draw_word(w);
        send_word(w, 1'b0, '0);
      end
    end

    drain_results();
    repeat (300) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/llbq_pkg.sv
design/llbq_if.sv
design/llbq_ram.sv
design/llbq_unit.sv
design/landmark_lower_bound_query_top.sv
verif/landmark_lower_bound_query_top_tb.sv
